### hw/rtl/kal_pkg.sv
package kal_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 11;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int ENTRY_W   = NODE_W + 1;
  localparam int COUNT_W   = 11;
  localparam int JUMP_W    = 11;
  localparam int ADDR_W    = LVL_W + NODE_W;
  localparam int MEM_DEPTH = LEVELS * MAX_NODES;

  localparam logic [ENTRY_W-1:0] ENTRY_NONE = '1;
  localparam logic [LVL_W-1:0]   LVL_LAST   = LVL_W'(LEVELS - 1);

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BUILD = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B_MID,
    ST_B_JUMP,
    ST_Q_STEP,
    ST_Q_WAIT
  } state_t;

  function automatic logic [ADDR_W-1:0] jt_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [NODE_W-1:0] node);
    return {lvl, node};
  endfunction

  function automatic logic names_node(input logic [ENTRY_W-1:0] e,
                                      input logic [COUNT_W-1:0] cnt);
    return !e[ENTRY_W-1] && (COUNT_W'(e) < cnt);
  endfunction

endpackage

### hw/rtl/kth_ancestor_binary_lifting.sv
// k-th ancestor lookup over a rooted forest, kept as a binary-lifting jump table.
// Requests: start with mode, node_index, parent_value and jump_count; a request
// is taken at a clock edge where start is high and busy is low.
//   load  : writes the parent of node_index into level 0; gives no result.
//   build : fills levels 1 to LEVELS-1 for nodes below node_count, then strobes
//           result_valid with build_done high; each entry takes ST_B_MID, and
//           ST_B_JUMP too when its midpoint names a node, as set by the single
//           read port of the table memory.
//   query : climbs the set bits of jump_count level by level, through ST_Q_STEP
//           at each level and ST_Q_WAIT for the memory read at each set bit;
//           ancestor_index -1 when none.
// Results are shown for one cycle with result_valid; there is no back-pressure.
// node_count is written through cfg_wr / cfg_data, by the user only while the
// block is idle (not enforced). Reset sets node_count to 1024 and returns to idle;
// table contents are kept and count as undefined until loaded or built.
module kth_ancestor_binary_lifting import kal_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [1:0]                mode,
  input  logic [NODE_W-1:0]         node_index,
  input  logic signed [ENTRY_W-1:0] parent_value,
  input  logic [JUMP_W-1:0]         jump_count,
  input  logic                      cfg_wr,
  input  logic [COUNT_W-1:0]        cfg_data,
  output logic                      busy,
  output logic                      result_valid,
  output logic signed [ENTRY_W-1:0] ancestor_index,
  output logic                      build_done
);

  logic [ENTRY_W-1:0] mem [MEM_DEPTH];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata;

  state_t             state, state_next;
  logic [LVL_W-1:0]   lvl, lvl_next;
  logic [NODE_W-1:0]  node, node_next;
  logic [ENTRY_W-1:0] ans, ans_next;
  logic [LEVELS-1:0]  jumps, jumps_next;
  logic [COUNT_W-1:0] node_count;
  logic [COUNT_W-1:0] cnt;
  logic               accept;
  logic               last_node;
  logic               last_entry;
  logic               mid_ok;
  logic               query_oor;
  logic               advance;
  logic               res_valid_next;
  logic [ENTRY_W-1:0] res_anc_next;
  logic               res_done_next;

  assign accept     = start && !busy;
  assign busy       = (state != ST_IDLE);
  assign cnt        = (node_count > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : node_count;
  assign last_node  = (COUNT_W'(node) == cnt - 1'b1);
  assign last_entry = last_node && (lvl == LVL_LAST);
  assign mid_ok     = names_node(rd_data, cnt);
  assign query_oor  = (COUNT_W'(node_index) >= cnt) || ((jump_count >> LEVELS) != '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      rd_data <= mem_wdata;
    end else begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      node_count   <= COUNT_W'(MAX_NODES);
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_valid_next;
      if (cfg_wr) begin
        node_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl            <= lvl_next;
    node           <= node_next;
    ans            <= ans_next;
    jumps          <= jumps_next;
    ancestor_index <= res_anc_next;
    build_done     <= res_done_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_BUILD) && (cnt != '0)) begin
          state_next = ST_B_MID;
        end else if (accept && (mode == MODE_QUERY) && !query_oor) begin
          state_next = ST_Q_STEP;
        end
      end
      ST_B_MID: begin
        if (mid_ok) begin
          state_next = ST_B_JUMP;
        end else if (last_entry) begin
          state_next = ST_IDLE;
        end
      end
      ST_B_JUMP: begin
        state_next = last_entry ? ST_IDLE : ST_B_MID;
      end
      ST_Q_STEP: begin
        if (jumps[lvl]) begin
          state_next = ST_Q_WAIT;
        end else if (lvl == LVL_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_Q_WAIT: begin
        state_next = (!mid_ok || (lvl == LVL_LAST)) ? ST_IDLE : ST_Q_STEP;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    lvl_next       = lvl;
    node_next      = node;
    ans_next       = ans;
    jumps_next     = jumps;
    mem_we         = 1'b0;
    mem_waddr      = jt_addr(lvl, node);
    mem_wdata      = rd_data;
    mem_raddr      = jt_addr(lvl, node);
    res_valid_next = 1'b0;
    res_anc_next   = ans;
    res_done_next  = 1'b0;
    advance        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_LOAD: begin
              if (COUNT_W'(node_index) < cnt) begin
                mem_we    = 1'b1;
                mem_waddr = jt_addr('0, node_index);
                mem_wdata = parent_value;
              end
            end
            MODE_BUILD: begin
              if (cnt == '0) begin
                res_valid_next = 1'b1;
                res_anc_next   = '0;
                res_done_next  = 1'b1;
              end else begin
                lvl_next  = LVL_W'(1);
                node_next = '0;
                mem_raddr = jt_addr('0, '0);
              end
            end
            MODE_QUERY: begin
              if (query_oor) begin
                res_valid_next = 1'b1;
                res_anc_next   = ENTRY_NONE;
              end else begin
                ans_next   = ENTRY_W'(node_index);
                jumps_next = jump_count[LEVELS-1:0];
                lvl_next   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_B_MID: begin
        if (mid_ok) begin
          mem_raddr = jt_addr(lvl - 1'b1, rd_data[NODE_W-1:0]);
        end else begin
          mem_we    = 1'b1;
          mem_wdata = ENTRY_NONE;
          advance   = 1'b1;
        end
      end
      ST_B_JUMP: begin
        mem_we  = 1'b1;
        advance = 1'b1;
      end
      ST_Q_STEP: begin
        if (jumps[lvl]) begin
          mem_raddr = jt_addr(lvl, ans[NODE_W-1:0]);
        end else if (lvl == LVL_LAST) begin
          res_valid_next = 1'b1;
        end else begin
          lvl_next = lvl + 1'b1;
        end
      end
      ST_Q_WAIT: begin
        if (!mid_ok) begin
          res_valid_next = 1'b1;
          res_anc_next   = ENTRY_NONE;
        end else begin
          ans_next = rd_data;
          if (lvl == LVL_LAST) begin
            res_valid_next = 1'b1;
            res_anc_next   = rd_data;
          end else begin
            lvl_next = lvl + 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (advance) begin
      if (last_entry) begin
        res_valid_next = 1'b1;
        res_anc_next   = '0;
        res_done_next  = 1'b1;
      end else if (last_node) begin
        lvl_next  = lvl + 1'b1;
        node_next = '0;
        mem_raddr = jt_addr(lvl, '0);
      end else begin
        node_next = node + 1'b1;
        mem_raddr = jt_addr(lvl - 1'b1, node + 1'b1);
      end
    end
  end

endmodule

### hw/rtl/kal_checker.sv
module kal_checker import kal_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic [1:0]                mode,
  input logic                      busy,
  input logic                      result_valid,
  input logic signed [ENTRY_W-1:0] ancestor_index,
  input logic                      build_done
);

  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  a_build_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && build_done) |-> (ancestor_index == '0))
    else $error("build result carries an ancestor");

  a_answer_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !build_done) |-> (!ancestor_index[ENTRY_W-1] || ancestor_index == '1))
    else $error("query answer out of range");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode != MODE_BUILD) && (mode != MODE_QUERY)) |=> !result_valid)
    else $error("load or unused request gave a result");

  a_work_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_BUILD || mode == MODE_QUERY)) |=> (busy || result_valid))
    else $error("request dropped");

endmodule

bind kth_ancestor_binary_lifting kal_checker u_kal_checker (.*);
